// ===== hw/rtl/bed_grid_index_mapper_core_assert.svh =====
// Assertion macros for the bed grid index mapper checker.
`ifndef BED_GRID_INDEX_MAPPER_CORE_ASSERT_SVH
`define BED_GRID_INDEX_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BGIM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BGIM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bgim_pkg.sv =====
// Shared constants, fault codes and helpers for the bed grid index mapper.
package bgim_pkg;

    localparam int COORD_BITS_DEF = 16;

    localparam logic [30:0] QUAD_OFFSET = 31'd536870911;
    localparam logic [30:0] QUAD_OFF2   = 31'(2 * QUAD_OFFSET);
    localparam logic [30:0] QUAD_OFF3   = 31'(3 * QUAD_OFFSET);
    localparam logic [30:0] QUAD_OFF4   = 31'(4 * QUAD_OFFSET);

    localparam int RAD_W      = 30;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int NUM_STAGES = 11;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_RANGE     = 2'd1,
        FAULT_NEG_INDEX = 2'd2,
        FAULT_QUAD      = 2'd3
    } fault_t;

    function automatic logic [30:0] quad_base(input logic [1:0] quad);
        logic [30:0] base;
        case (quad)
            2'd0:    base = '0;
            2'd1:    base = QUAD_OFFSET;
            2'd2:    base = QUAD_OFF2;
            2'd3:    base = QUAD_OFF3;
            default: base = '0;
        endcase
        return base;
    endfunction

endpackage

// ===== hw/rtl/bed_grid_index_mapper_core.sv =====
// Bed grid index mapper: 11-stage pipelined coordinate/index converter.
//
// Request channel (req_valid/req_ready) carries kind, coord_x, coord_y and
// cell_index; response channel (rsp_valid/rsp_ready) carries index_out,
// x_out, y_out and fault. kind 0 maps coordinates to an index, kind 1 maps
// an index back to coordinates; fields of the other direction read zero.
// One transaction is accepted per cycle while rsp_ready keeps the stages moving;
// the stages are the 15-step square root at up to two steps a stage,
// plus the quadrant split in front and the unfold and sign stages behind.
// The forward path's 16x16 square sits in its own stage alongside.
// Every stage holds a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so a stalled rsp_ready backs up only full stages
// and bubbles still close up. Nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) empties all stages; no other state.
// COORD_BITS sets how many low bits of coord_x/coord_y are used and the
// range that inverse coordinates must fit.
module bed_grid_index_mapper_core
    import bgim_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic               kind,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic signed [31:0] cell_index,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic        [30:0] index_out,
    output logic signed [15:0] x_out,
    output logic signed [15:0] y_out,
    output logic        [1:0]  fault
);

    localparam int SQ_W = 2 * COORD_BITS;
    localparam int LAST = NUM_STAGES - 1;
    localparam logic [REM_W-1:0] MAG_LIM = REM_W'(1 << (COORD_BITS - 1));

    typedef struct packed {
        logic                  kind;
        logic [1:0]            quad;
        fault_t                fault;
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
        logic [COORD_BITS-1:0] a;
        logic                  eq;
        logic                  gt;
        logic [SQ_W-1:0]       sq;
        logic [30:0]           idx;
        logic [RAD_W-1:0]      rad;
        logic [REM_W-1:0]      rem;
        logic [ROOT_W-1:0]     root;
        logic [ROOT_W-1:0]     mx;
        logic [ROOT_W-1:0]     my;
        logic [15:0]           xo;
        logic [15:0]           yo;
    } stage_t;

    function automatic stage_t sqrt_step(input stage_t s);
        stage_t           o;
        logic [REM_W-1:0] trial_rem;
        logic [REM_W-1:0] trial;
        o = s;
        trial_rem = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
        trial     = {s.root, 2'b01};
        if (trial_rem >= trial)
        begin
            o.rem  = trial_rem - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = trial_rem;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        o.rad = {s.rad[RAD_W-3:0], 2'b00};
        return o;
    endfunction

    stage_t pipe_reg  [NUM_STAGES];
    stage_t pipe_next [NUM_STAGES];
    logic   valid_reg   [NUM_STAGES];
    logic   valid_next  [NUM_STAGES];
    logic   up_valid    [NUM_STAGES];
    logic   stage_ready [NUM_STAGES];

    logic [COORD_BITS-1:0] xs;
    logic [COORD_BITS-1:0] ys;
    logic [30:0]           idx_val;
    logic                  ge1, ge2, ge3, ge4;
    logic [1:0]            inv_q;
    logic [28:0]           inv_r;

    // Stage 0: magnitudes and signs; quadrant split of the index.
    always_comb
    begin
        xs      = coord_x[COORD_BITS-1:0];
        ys      = coord_y[COORD_BITS-1:0];
        idx_val = cell_index[30:0];
        ge1     = idx_val >= QUAD_OFFSET;
        ge2     = idx_val >= QUAD_OFF2;
        ge3     = idx_val >= QUAD_OFF3;
        ge4     = idx_val >= QUAD_OFF4;
        inv_q   = ge3 ? 2'd3 : (ge2 ? 2'd2 : (ge1 ? 2'd1 : 2'd0));
        inv_r   = 29'(idx_val - quad_base(inv_q));

        pipe_next[0]      = '0;
        pipe_next[0].kind = kind;
        if (!kind)
        begin
            pipe_next[0].ax   = xs[COORD_BITS-1] ? (~xs + 1'b1) : xs;
            pipe_next[0].ay   = ys[COORD_BITS-1] ? (~ys + 1'b1) : ys;
            pipe_next[0].quad = {xs[COORD_BITS-1], ys[COORD_BITS-1]};
        end
        else
        begin
            pipe_next[0].quad = inv_q;
            pipe_next[0].rad  = {1'b0, inv_r};
            if (cell_index[31])
                pipe_next[0].fault = FAULT_NEG_INDEX;
            else if (ge4)
                pipe_next[0].fault = FAULT_QUAD;
            else
                pipe_next[0].fault = FAULT_NONE;
        end
    end

    // Stages 1..8: square root up to two steps a stage; forward shell math alongside.
    for (genvar gs = 1; gs <= 8; gs++)
    begin : g_root
        always_comb
        begin : stage_comb
            stage_t          s;
            logic [SQ_W-1:0] a_w;
            logic [SQ_W-1:0] ax_w;
            logic [SQ_W-1:0] ay_w;
            s = sqrt_step(pipe_reg[gs-1]);
            if (2 * gs <= SQRT_STEPS)
                s = sqrt_step(s);
            a_w  = SQ_W'(s.a);
            ax_w = SQ_W'(s.ax);
            ay_w = SQ_W'(s.ay);
            if (gs == 1)
            begin
                s.eq = s.ax == s.ay;
                s.gt = s.ax > s.ay;
                s.a  = (s.gt ? s.ax : s.ay) + 1'b1;
            end
            if (gs == 2)
                s.sq = a_w * a_w;
            if (gs == 3)
            begin
                if (s.eq)
                    s.sq = s.sq - SQ_W'(1);
                else if (s.gt)
                    s.sq = s.sq - (a_w << 1) + ay_w + SQ_W'(1);
                else
                    s.sq = s.sq - a_w + ax_w;
            end
            if (gs == 4 && !s.kind)
            begin
                if (32'(s.sq) >= 32'(QUAD_OFFSET))
                begin
                    s.fault = FAULT_RANGE;
                    s.idx   = '0;
                end
                else
                    s.idx = quad_base(s.quad) + 31'(s.sq);
            end
            pipe_next[gs] = s;
        end
    end

    // Stage 9: unfold the shell remainder into two magnitudes.
    always_comb
    begin
        pipe_next[9] = pipe_reg[8];
        if (pipe_reg[8].rem < {2'b00, pipe_reg[8].root})
        begin
            pipe_next[9].mx = pipe_reg[8].root;
            pipe_next[9].my = pipe_reg[8].rem[ROOT_W-1:0];
        end
        else
        begin
            pipe_next[9].mx = ROOT_W'(pipe_reg[8].rem - {2'b00, pipe_reg[8].root});
            pipe_next[9].my = pipe_reg[8].root;
        end
    end

    // Stage 10: signs, range check, zeroing of unused fields.
    always_comb
    begin : sign_comb
        logic             neg_x;
        logic             neg_y;
        logic             bad;
        logic [15:0]      mx_w;
        logic [15:0]      my_w;
        logic [REM_W-1:0] mx_e;
        logic [REM_W-1:0] my_e;
        neg_x = pipe_reg[9].quad[1];
        neg_y = pipe_reg[9].quad[0];
        mx_w  = {1'b0, pipe_reg[9].mx};
        my_w  = {1'b0, pipe_reg[9].my};
        mx_e  = REM_W'(pipe_reg[9].mx);
        my_e  = REM_W'(pipe_reg[9].my);
        bad   = (neg_x ? (mx_e > MAG_LIM) : (mx_e >= MAG_LIM))
              | (neg_y ? (my_e > MAG_LIM) : (my_e >= MAG_LIM));

        pipe_next[10]    = pipe_reg[9];
        pipe_next[10].xo = '0;
        pipe_next[10].yo = '0;
        if (pipe_reg[9].kind && pipe_reg[9].fault == FAULT_NONE)
        begin
            if (bad)
                pipe_next[10].fault = FAULT_RANGE;
            else
            begin
                pipe_next[10].xo = neg_x ? (~mx_w + 16'd1) : mx_w;
                pipe_next[10].yo = neg_y ? (~my_w + 16'd1) : my_w;
            end
        end
    end

    always_comb
    begin
        stage_ready[LAST] = !valid_reg[LAST] || rsp_ready;
        for (int i = LAST - 1; i >= 0; i--)
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        up_valid[0] = req_valid;
        for (int i = 1; i < NUM_STAGES; i++)
            up_valid[i] = valid_reg[i-1];
        for (int i = 0; i < NUM_STAGES; i++)
            valid_next[i] = stage_ready[i] ? up_valid[i] : valid_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_STAGES; i++)
                valid_reg[i] <= valid_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            if (stage_ready[i] && up_valid[i])
                pipe_reg[i] <= pipe_next[i];
        end
    end

    assign req_ready = stage_ready[0];
    assign rsp_valid = valid_reg[LAST];
    assign index_out = pipe_reg[LAST].idx;
    assign x_out     = pipe_reg[LAST].xo;
    assign y_out     = pipe_reg[LAST].yo;
    assign fault     = pipe_reg[LAST].fault;

endmodule

// ===== hw/rtl/bgim_checker.sv =====
// Port-level assertion checker for the bed grid index mapper, with its bind.
`include "bed_grid_index_mapper_core_assert.svh"

module bgim_checker
    import bgim_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               kind,
    input logic signed [15:0] coord_x,
    input logic signed [15:0] coord_y,
    input logic signed [31:0] cell_index,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic        [30:0] index_out,
    input logic signed [15:0] x_out,
    input logic signed [15:0] y_out,
    input logic        [1:0]  fault
);

    logic        req_stall;
    logic        rsp_stall;
    logic        rsp_has_xy;
    logic        rsp_zero;
    logic        rsp_idx_clear;
    logic [64:0] req_bus;
    logic [64:0] rsp_bus;

    assign req_stall     = req_valid && !req_ready;
    assign rsp_stall     = rsp_valid && !rsp_ready;
    assign req_bus       = {kind, coord_x, coord_y, cell_index};
    assign rsp_bus       = {index_out, x_out, y_out, fault};
    assign rsp_has_xy    = x_out != 16'sd0 || y_out != 16'sd0;
    assign rsp_zero      = index_out == 31'd0 && !rsp_has_xy;
    assign rsp_idx_clear = index_out == 31'd0 && fault == FAULT_NONE;

    `BGIM_ASSERT_NEXT(a_req_hold, req_stall, req_valid && $stable(req_bus), "request not held")

    `BGIM_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_bus), "response not held")

    `BGIM_ASSERT_NOW(a_fault_zero, rsp_valid && fault != FAULT_NONE, rsp_zero, "fault with values")

    `BGIM_ASSERT_NOW(a_one_direction, rsp_valid && rsp_has_xy, rsp_idx_clear, "mixed directions")

    `BGIM_ASSERT_NOW(a_index_bound, rsp_valid, index_out < QUAD_OFF4, "index past last quadrant")

endmodule

bind bed_grid_index_mapper_core bgim_checker u_bgim_checker (.*);
